[src/cfir_pkg.sv]
// shared types and constants for the complex fir with real taps
package cfir_pkg;

   localparam int DATA_W    = 16;
   localparam int PROD_W    = 2 * DATA_W;
   localparam int IDX_W     = 6;
   localparam int TAPCNT_W  = 7;
   localparam int FRAC_W    = 15;
   localparam int REQ_TDATA_W = 56;
   localparam int RSP_TDATA_W = 32;
   localparam int ROUND_BIAS = 16384;
   localparam int OUT_MAX    = 32767;
   localparam int OUT_MIN    = -32768;
   localparam logic [TAPCNT_W-1:0] TAPCNT_RESET = 7'd64;

   localparam logic KIND_COEF   = 1'b0;
   localparam logic KIND_SAMPLE = 1'b1;

   typedef struct packed {
      logic signed [DATA_W-1:0] im;
      logic signed [DATA_W-1:0] re;
   } cfir_sample_type;

   typedef struct packed {
      logic shift;
      logic coef_we;
      logic tap_en;
   } cfir_cell_ctrl_type;

endpackage

[src/cfir_cell.sv]
// one tap cell: delay entry, coefficient, product and partial sum
module cfir_cell import cfir_pkg::*; #(
   parameter int ACC_W = 38
) (
   input  logic                     clock,
   input  logic                     reset,
   input  cfir_cell_ctrl_type       ctrl,
   input  cfir_sample_type          sample_in,
   input  logic signed [DATA_W-1:0] coef_value,
   input  logic signed [ACC_W-1:0]  sum_re_prev,
   input  logic signed [ACC_W-1:0]  sum_im_prev,
   output cfir_sample_type          sample_out,
   output logic signed [ACC_W-1:0]  sum_re_out,
   output logic signed [ACC_W-1:0]  sum_im_out
);

   cfir_sample_type          smp_ff, smp_in;
   logic signed [DATA_W-1:0] coef_ff, coef_in;
   logic signed [PROD_W-1:0] prod_re_ff, prod_re_in;
   logic signed [PROD_W-1:0] prod_im_ff, prod_im_in;
   logic signed [ACC_W-1:0]  sum_re_ff, sum_re_in;
   logic signed [ACC_W-1:0]  sum_im_ff, sum_im_in;
   logic signed [ACC_W-1:0]  add_re, add_im;

   always_comb begin
      smp_in     = ctrl.shift   ? sample_in  : smp_ff;
      coef_in    = ctrl.coef_we ? coef_value : coef_ff;
      prod_re_in = smp_ff.re * coef_ff;
      prod_im_in = smp_ff.im * coef_ff;
      add_re     = {{(ACC_W-PROD_W){prod_re_ff[PROD_W-1]}}, prod_re_ff};
      add_im     = {{(ACC_W-PROD_W){prod_im_ff[PROD_W-1]}}, prod_im_ff};
      sum_re_in  = ctrl.tap_en ? sum_re_prev + add_re : sum_re_prev;
      sum_im_in  = ctrl.tap_en ? sum_im_prev + add_im : sum_im_prev;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         smp_ff  <= '0;
         coef_ff <= '0;
      end else begin
         smp_ff  <= smp_in;
         coef_ff <= coef_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_re_ff <= prod_re_in;
      prod_im_ff <= prod_im_in;
      sum_re_ff  <= sum_re_in;
      sum_im_ff  <= sum_im_in;
   end

   assign sample_out = smp_ff;
   assign sum_re_out = sum_re_ff;
   assign sum_im_out = sum_im_ff;

endmodule

[src/cfir_out.sv]
// result stage: rounding, saturation and the output register
module cfir_out import cfir_pkg::*; #(
   parameter int ACC_W = 38
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load,
   input  logic signed [ACC_W-1:0] acc_re,
   input  logic signed [ACC_W-1:0] acc_im,
   input  logic                    last,
   output logic                    free,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [RSP_TDATA_W-1:0]  rsp_tdata,
   output logic                    rsp_tlast
);

   localparam logic signed [ACC_W:0] Q_MAX = (ACC_W+1)'(OUT_MAX);
   localparam logic signed [ACC_W:0] Q_MIN = (ACC_W+1)'(OUT_MIN);
   localparam logic signed [ACC_W:0] BIAS  = (ACC_W+1)'(ROUND_BIAS);

   logic                     valid_ff, valid_in;
   logic signed [DATA_W-1:0] re_ff, re_in;
   logic signed [DATA_W-1:0] im_ff, im_in;
   logic                     last_ff, last_in;

   function automatic logic signed [DATA_W-1:0] round_sat(
      input logic signed [ACC_W-1:0] acc
   );
      logic signed [ACC_W:0] biased;
      logic signed [ACC_W:0] q;
      biased = {acc[ACC_W-1], acc} + BIAS;
      q      = biased >>> FRAC_W;
      if (q > Q_MAX) begin
         return DATA_W'(OUT_MAX);
      end else if (q < Q_MIN) begin
         return DATA_W'(OUT_MIN);
      end else begin
         return q[DATA_W-1:0];
      end
   endfunction

   assign free = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      re_in    = re_ff;
      im_in    = im_ff;
      last_in  = last_ff;
      if (valid_ff && rsp_tready) begin
         valid_in = 1'b0;
      end
      if (load) begin
         valid_in = 1'b1;
         re_in    = round_sat(acc_re);
         im_in    = round_sat(acc_im);
         last_in  = last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      re_ff   <= re_in;
      im_ff   <= im_in;
      last_ff <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {im_ff, re_ff};
   assign rsp_tlast  = last_ff;

endmodule

[src/complex_fir_real_taps.sv]
// complex fir with real taps: row of tap cells, sequencer and result stage
// a sample word starts a run: its partial sum travels down the row of tap cells and is
// rounded into the result stage, waiting in hold while that stage is full; no request word
//   is taken until the run ends; coefficient words are taken in idle without a run
// reset: synchronous, delay line and coefficients cleared, tap count set to 64
module complex_fir_real_taps import cfir_pkg::*; #(
   parameter int MAX_TAPS = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // coef_index, coef_value, sample_re, sample_im, zero fill
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // kind
   input  logic [0:0]             req_tuser,
   input  logic                   req_tlast,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // out_re, out_im
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic                   rsp_tlast,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [TAPCNT_W-1:0]    csr_data
);

   localparam int ACC_W = PROD_W + $clog2(MAX_TAPS);
   localparam int CNT_W = $clog2(MAX_TAPS + 2);
   localparam logic [CNT_W-1:0] RUN_LEN = CNT_W'(MAX_TAPS + 1);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_RUN  = 3'b010,
      ST_HOLD = 3'b100
   } cfir_state_type;

   cfir_state_type        state_ff, state_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [TAPCNT_W-1:0]   tapcnt_ff, tapcnt_in;
   logic                  last_ff, last_in;

   logic                     req_acc;
   logic                     shift, coef_we;
   logic [IDX_W-1:0]         coef_index;
   logic signed [DATA_W-1:0] coef_value;
   cfir_sample_type          new_sample;
   logic                     out_free, out_load;

   cfir_sample_type         smp_chain [MAX_TAPS+1];
   logic signed [ACC_W-1:0] sum_re [MAX_TAPS+1];
   logic signed [ACC_W-1:0] sum_im [MAX_TAPS+1];

   assign coef_index    = req_tdata[IDX_W-1:0];
   assign coef_value    = req_tdata[IDX_W+DATA_W-1:IDX_W];
   assign new_sample.re = req_tdata[IDX_W+2*DATA_W-1:IDX_W+DATA_W];
   assign new_sample.im = req_tdata[IDX_W+3*DATA_W-1:IDX_W+2*DATA_W];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign shift      = req_acc && (req_tuser[0] == KIND_SAMPLE);
   assign coef_we    = req_acc && (req_tuser[0] == KIND_COEF);
   assign csr_ready  = 1'b1;

   assign out_load = out_free &&
                     (((state_ff == ST_RUN) && (cnt_ff == '0)) || (state_ff == ST_HOLD));

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      tapcnt_in = tapcnt_ff;
      last_in   = last_ff;
      if (csr_valid && csr_ready) begin
         tapcnt_in = csr_data;
      end
      case (state_ff)
         ST_IDLE: begin
            if (shift) begin
               state_in = ST_RUN;
               cnt_in   = RUN_LEN;
               last_in  = req_tlast;
            end
         end
         ST_RUN: begin
            if (cnt_ff != '0) begin
               cnt_in = cnt_ff - 1'b1;
            end else if (out_load) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         cnt_ff    <= '0;
         tapcnt_ff <= TAPCNT_RESET;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         tapcnt_ff <= tapcnt_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff <= last_in;
   end

   assign smp_chain[0] = new_sample;
   assign sum_re[0]    = '0;
   assign sum_im[0]    = '0;

   for (genvar i = 0; i < MAX_TAPS; i++) begin : g_cell
      cfir_cell_ctrl_type ctrl;

      assign ctrl.shift   = shift;
      assign ctrl.coef_we = coef_we && (int'(coef_index) == i);
      assign ctrl.tap_en  = (i == 0) || (int'(tapcnt_ff) > i);

      cfir_cell #(
         .ACC_W (ACC_W)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .sample_in   (smp_chain[i]),
         .coef_value  (coef_value),
         .sum_re_prev (sum_re[i]),
         .sum_im_prev (sum_im[i]),
         .sample_out  (smp_chain[i+1]),
         .sum_re_out  (sum_re[i+1]),
         .sum_im_out  (sum_im[i+1])
      );
   end

   cfir_out #(
      .ACC_W (ACC_W)
   ) u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (out_load),
      .acc_re     (sum_re[MAX_TAPS]),
      .acc_im     (sum_im[MAX_TAPS]),
      .last       (last_ff),
      .free       (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

[dv/complex_fir_real_taps_test.sv]
// testbench for the complex fir with real taps: scoreboard class, stream drivers and checks
module complex_fir_real_taps_test import cfir_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_TAPS      = 64;
   localparam int SETTLE_CYCLES = MAX_TAPS + 20;
   localparam int HOLD_CYCLES   = 1200;
   localparam int PHASE_WORDS   = 95;
   localparam int CYCLE_LIMIT   = 1000000;

   typedef struct packed {
      logic                     kind;
      logic [IDX_W-1:0]         coef_index;
      logic signed [DATA_W-1:0] coef_value;
      logic signed [DATA_W-1:0] sample_re;
      logic signed [DATA_W-1:0] sample_im;
      logic                     block_end;
   } filter_word_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] re;
      logic signed [DATA_W-1:0] im;
      logic                     last;
   } filtered_type;

   class fir_scoreboard;
      logic signed [DATA_W-1:0] line_re [MAX_TAPS];
      logic signed [DATA_W-1:0] line_im [MAX_TAPS];
      logic signed [DATA_W-1:0] taps [MAX_TAPS];
      int unsigned tap_count;
      filtered_type filtered_q [$];
      int unsigned mismatches;
      int unsigned checked;

      function new();
         foreach (taps[i]) begin
            line_re[i] = '0;
            line_im[i] = '0;
            taps[i] = '0;
         end
         tap_count = TAPCNT_RESET;
         mismatches = 0;
         checked = 0;
      endfunction

      function void set_taps(logic [TAPCNT_W-1:0] value);
         tap_count = value;
      endfunction

      function int pending();
         return filtered_q.size();
      endfunction

      function logic signed [DATA_W-1:0] round_sat(longint acc);
         longint q;
         q = (acc + ROUND_BIAS) >>> FRAC_W;
         if (q > OUT_MAX) q = OUT_MAX;
         if (q < OUT_MIN) q = OUT_MIN;
         return q[DATA_W-1:0];
      endfunction

      function void accept_word(filter_word_type w);
         int i;
         int unsigned n;
         longint acc_re;
         longint acc_im;
         filtered_type r;
         if (w.kind == KIND_COEF) begin
            taps[w.coef_index] = w.coef_value;
            return;
         end
         for (i = MAX_TAPS - 1; i > 0; i--) begin
            line_re[i] = line_re[i-1];
            line_im[i] = line_im[i-1];
         end
         line_re[0] = w.sample_re;
         line_im[0] = w.sample_im;
         n = tap_count;
         if (n < 1) n = 1;
         if (n > MAX_TAPS) n = MAX_TAPS;
         acc_re = 0;
         acc_im = 0;
         for (i = 0; i < n; i++) begin
            acc_re += longint'(line_re[i]) * longint'(taps[i]);
            acc_im += longint'(line_im[i]) * longint'(taps[i]);
         end
         r.re = round_sat(acc_re);
         r.im = round_sat(acc_im);
         r.last = w.block_end;
         filtered_q.push_back(r);
      endfunction

      function void compare_output(logic [RSP_TDATA_W-1:0] data, logic last);
         filtered_type got;
         filtered_type want;
         got.re = data[DATA_W-1:0];
         got.im = data[2*DATA_W-1:DATA_W];
         got.last = last;
         if (filtered_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result word: re=%0d im=%0d last=%0b",
                        got.re, got.im, got.last);
            return;
         end
         want = filtered_q.pop_front();
         checked++;
         if (got.re !== want.re || got.im !== want.im || got.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"mismatch on result %0d: expected re=%0d im=%0d last=%0b, ",
                         "got re=%0d im=%0d last=%0b"},
                        checked, want.re, want.im, want.last, got.re, got.im, got.last);
         end
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic [0:0]             req_tuser = '0;
   logic                   req_tlast = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tlast;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [TAPCNT_W-1:0]    csr_data = '0;

   fir_scoreboard board;
   bit          calm = 1'b0;
   bit          hold_request = 1'b0;
   int          hold_left = 0;
   int          rsp_gap = 0;
   int unsigned cycles = 0;
   int unsigned sample_words = 0;
   int unsigned coef_words = 0;
   int unsigned tap_settings = 0;

   complex_fir_real_taps dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("complex_fir_real_taps_test NOT OK");
         $finish;
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(20, 90);
   endfunction

   function automatic logic signed [DATA_W-1:0] pick_value();
      case ($urandom_range(0, 11))
         0: return 16'sh8000;
         1: return 16'sh7fff;
         2: return 16'sh0000;
         3: return 16'shffff;
         default: return DATA_W'($urandom());
      endcase
   endfunction

   function automatic filter_word_type make_coef(int idx, logic signed [DATA_W-1:0] value);
      filter_word_type w;
      w.kind = KIND_COEF;
      w.coef_index = IDX_W'(idx);
      w.coef_value = value;
      w.sample_re = DATA_W'($urandom());
      w.sample_im = DATA_W'($urandom());
      w.block_end = 1'($urandom_range(0, 1));
      return w;
   endfunction

   function automatic filter_word_type make_sample(logic signed [DATA_W-1:0] re,
                                                   logic signed [DATA_W-1:0] im, logic last);
      filter_word_type w;
      w.kind = KIND_SAMPLE;
      w.coef_index = IDX_W'($urandom_range(0, MAX_TAPS - 1));
      w.coef_value = DATA_W'($urandom());
      w.sample_re = re;
      w.sample_im = im;
      w.block_end = last;
      return w;
   endfunction

   function automatic filter_word_type random_word();
      if ($urandom_range(0, 9) < 3)
         return make_coef($urandom_range(0, MAX_TAPS - 1), pick_value());
      return make_sample(pick_value(), pick_value(), $urandom_range(0, 3) == 0);
   endfunction

   task automatic send_word(filter_word_type w);
      int gap;
      gap = calm ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {2'b00, w.sample_im, w.sample_re, w.coef_value, w.coef_index};
      req_tuser <= w.kind;
      req_tlast <= w.block_end;
      do @(posedge clock); while (!req_tready);
      board.accept_word(w);
      if (w.kind == KIND_SAMPLE) sample_words++;
      else coef_words++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (board.pending() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_taps(logic [TAPCNT_W-1:0] value);
      drain();
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      board.set_taps(value);
      csr_valid <= 1'b0;
      tap_settings++;
   endtask

   // receive side: random back-pressure plus one long hold
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) board.compare_output(rsp_tdata, rsp_tlast);
         if (hold_request) begin
            hold_left = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (rsp_gap == 0 && !calm && $urandom_range(0, 7) == 0) rsp_gap = pick_gap();
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      int p;
      int k;
      int tap_plan [9];
      board = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset tap count, ties and saturation
      send_word(make_coef(0, 16'sd16384));
      send_word(make_sample(16'sd1, -16'sd1, 1'b0));
      send_word(make_sample(-16'sd1, 16'sd1, 1'b0));
      send_word(make_coef(0, 16'sh8000));
      send_word(make_coef(1, 16'sh8000));
      send_word(make_sample(16'sh8000, 16'sh7fff, 1'b1));
      send_word(make_sample(16'sh8000, 16'sh8000, 1'b0));
      send_word(make_sample(16'sh7fff, 16'sh7fff, 1'b0));
      send_word(make_sample(16'sh7fff, 16'sh7fff, 1'b1));
      send_word(make_coef(MAX_TAPS - 1, 16'sh7fff));
      send_word(make_coef(MAX_TAPS - 2, 16'shffff));
      send_word(make_coef(31, 16'sh5555));
      send_word(make_sample(16'sh0000, 16'sh0000, 1'b0));
      send_word(make_sample(16'sh7fff, 16'sh8000, 1'b1));
      send_word(make_sample(16'shaaaa, 16'sh5555, 1'b0));
      send_word(make_coef(0, 16'sh0000));
      send_word(make_sample(16'shffff, 16'sh0001, 1'b1));

      tap_plan = '{1, 64, 0, 127, 65, 2, 17, 0, 0};
      tap_plan[7] = $urandom_range(3, 63);
      tap_plan[8] = $urandom_range(0, 127);
      for (p = 0; p < 9; p++) begin
         write_taps(TAPCNT_W'(tap_plan[p]));
         calm = (p % 3 == 2);
         for (k = 0; k < PHASE_WORDS; k++) begin
            if (p == 1 && k == 10) hold_request = 1'b1;
            if (p == 4 && k == PHASE_WORDS / 2) drain();
            send_word(random_word());
         end
      end

      calm = 1'b0;
      req_tvalid <= 1'b0;
      while (board.pending() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("covered %0d sample words and %0d coefficient words over %0d tap count settings",
               sample_words, coef_words, tap_settings);
      $display("%0d result words checked, %0d mismatches", board.checked, board.mismatches);
      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("complex_fir_real_taps_test OK");
      end else begin
         $display("complex_fir_real_taps_test NOT OK");
      end
      $finish;
   end

endmodule
